@@ design/rscu_pkg.sv @@
`default_nettype none

package rscu_pkg;

  // item codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // largest difference that is slewed instead of jumped
  localparam int unsigned SLEW_LIMIT = 127;

  localparam int unsigned SECS_W = 32;

  typedef struct packed {
    logic              operation;
    logic [SECS_W-1:0] target_time;
  } in_t;

  typedef struct packed {
    logic [SECS_W-1:0] seconds_now;
    logic              slewing;
    logic signed [7:0] error_left;
  } out_t;

  typedef struct packed {
    logic signed [7:0] err;
    logic [7:0]        budget;
  } slew_t;

endpackage

`default_nettype wire

@@ design/rtc_seconds_slew_corrector_unit.sv @@
`default_nettype none

// Channel   Ports                          Payload
// input     in_valid / in_ready            in_data  (in_t: operation, target_time)
// result    out_valid / out_ready          out_data (out_t: seconds_now, slewing, error_left)
//
// One item per cycle sustained while the result is taken; an item's result is offered once
// it has passed the input register and then the result register.
// The counter and slew state are updated as an item moves into the result register.
// rst_n (synchronous) clears the counter, the slew state and both valid flags.
// A stalled result holds; the input register still takes an item while empty.

module rtc_seconds_slew_corrector_unit
  import rscu_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_ready,
  output out_t out_data
);

  in_t                     in_r;
  logic                    in_valid_r;
  out_t                    out_r;
  logic                    out_valid_r;
  logic [COUNTER_BITS-1:0] cnt_r;
  logic [COUNTER_BITS-1:0] cnt_nxt;
  slew_t                   slew_r;
  slew_t                   slew_nxt;
  out_t                    result;
  logic                    fire;

  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  rscu_step #(
    .CNT_W(COUNTER_BITS)
  ) u_step (
    .item  (in_r),
    .cnt_q (cnt_r),
    .slew_q(slew_r),
    .cnt_d (cnt_nxt),
    .slew_d(slew_nxt),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      slew_r      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
        slew_r      <= slew_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [7:0] err_abs;
  assign err_abs = slew_r.err[7] ? 8'(-slew_r.err) : 8'(slew_r.err);

  // the slew error can never reach -128
  assert property (@(posedge clk) disable iff (!rst_n)
    slew_r.err != -8'sd128)
    else $error("slew error reached -128");

  // budget equals twice the error or is one less than that
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, slew_r.budget} <= {err_abs, 1'b0}) &&
    ({err_abs, 1'b0} <= {1'b0, slew_r.budget} + 9'd1))
    else $error("slew budget out of step with error");

  // a tick with no slew running advances the counter by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (in_r.operation == OP_TICK) &&
     ((slew_r.err == 8'sd0) || (slew_r.budget == 8'd0)))
    |=> (cnt_r == $past(cnt_r) + COUNTER_BITS'(1)))
    else $error("plain tick did not advance counter by one");

endmodule

`default_nettype wire

@@ design/rscu_step.sv @@
`default_nettype none

module rscu_step
  import rscu_pkg::*;
#(
  parameter int unsigned CNT_W = 32
) (
  input  in_t              item,
  input  logic [CNT_W-1:0] cnt_q,
  input  slew_t            slew_q,
  output logic [CNT_W-1:0] cnt_d,
  output slew_t            slew_d,
  output out_t             result
);

  logic [CNT_W-1:0] tgt_ext;
  logic [CNT_W-1:0] diff;
  logic [CNT_W-1:0] neg_diff;
  logic             near_ahead;
  logic             near_behind;
  logic             slewing_q;
  logic [7:0]       err_mag;
  logic [8:0]       err_twice;
  logic             correct;
  logic [1:0]       step;

  assign tgt_ext  = CNT_W'(item.target_time);
  assign diff     = cnt_q - tgt_ext;
  assign neg_diff = tgt_ext - cnt_q;

  assign near_ahead  = diff <= CNT_W'(SLEW_LIMIT);
  assign near_behind = diff[CNT_W-1] && (neg_diff <= CNT_W'(SLEW_LIMIT));

  assign slewing_q = (slew_q.err != 8'sd0) && (slew_q.budget != 8'd0);
  assign err_mag   = slew_q.err[7] ? 8'(-slew_q.err) : 8'(slew_q.err);
  assign err_twice = {err_mag, 1'b0};
  assign correct   = slewing_q && ({1'b0, slew_q.budget} < err_twice);

  always_comb begin
    if (!correct) begin
      step = 2'd1;
    end else if (slew_q.err[7]) begin
      step = 2'd2;  // behind: skip a second
    end else begin
      step = 2'd0;  // ahead: hold
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    slew_d = slew_q;
    case (item.operation)
      OP_SET: begin
        if (near_ahead) begin
          slew_d.err    = $signed(diff[7:0]);
          slew_d.budget = {diff[6:0], 1'b0};
        end else if (near_behind) begin
          // low byte of the difference is already the negative error
          slew_d.err    = $signed(diff[7:0]);
          slew_d.budget = {neg_diff[6:0], 1'b0};
        end else begin
          cnt_d = tgt_ext;
        end
      end
      OP_TICK: begin
        cnt_d = cnt_q + CNT_W'(step);
        if (slewing_q) begin
          slew_d.budget = slew_q.budget - 8'd1;
          if (correct) begin
            slew_d.err = slew_q.err[7] ? slew_q.err + 8'sd1 : slew_q.err - 8'sd1;
          end
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign result.seconds_now = SECS_W'(cnt_d);
  assign result.slewing     = (slew_d.err != 8'sd0) && (slew_d.budget != 8'd0);
  assign result.error_left  = slew_d.err;

endmodule

`default_nettype wire

@@ bench/rscu_slew_checker.sv @@
module rscu_slew_checker
  import rscu_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  in_t               in_data,
  input  wire               out_valid,
  input  wire               out_ready,
  input  out_t              out_data,
  output int                fail_count,
  output int                results_seen,
  output int                results_owed,
  output logic [SECS_W-1:0] counter_now
);

  logic [SECS_W-1:0] secs;
  logic signed [7:0] err;
  logic [7:0]        budget;
  out_t              owed_readings[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 30) begin
      $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    end
    fail_count++;
  endtask

  // Advance the clock state by one item and return the reading that follows.
  task automatic step_clock(input in_t item, output out_t reading);
    logic [SECS_W-1:0] diff;
    logic [SECS_W-1:0] adv;
    int                e;
    int                m;
    diff = secs - item.target_time;
    adv  = 1;
    if (item.operation == OP_SET) begin
      if (diff <= SLEW_LIMIT) begin
        err    = diff[7:0];
        budget = 8'(2 * diff);
      end else if (diff >= 32'hFFFF_FF81) begin
        // counter behind by at most the limit: slew with a negative error
        m      = int'(-diff);
        err    = 8'(-m);
        budget = 8'(2 * m);
      end else begin
        // far off: jump, leaving any running slew alone
        secs = item.target_time;
      end
    end else begin
      if (err != 0 && budget != 0) begin
        e = int'(err);
        m = (e < 0) ? -e : e;
        if (int'(budget) < 2 * m) begin
          if (e > 0) begin
            adv = 0;
            err = err - 8'sd1;
          end else begin
            adv = 2;
            err = err + 8'sd1;
          end
        end
        budget = budget - 8'd1;
      end
      secs = secs + adv;
    end
    reading.seconds_now = secs;
    reading.slewing     = (err != 0 && budget != 0);
    reading.error_left  = err;
  endtask

  always @(posedge clk) begin
    out_t got;
    out_t want;
    out_t fresh;
    if (!rst_n) begin
      secs   = '0;
      err    = '0;
      budget = '0;
      owed_readings.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (owed_readings.size() == 0) begin
          report("unexpected result seconds_now", got.seconds_now, '0);
        end else begin
          want = owed_readings.pop_front();
          results_seen++;
          if (got.seconds_now !== want.seconds_now)
            report("seconds_now", got.seconds_now, want.seconds_now);
          if (got.slewing !== want.slewing)
            report("slewing", 32'(got.slewing), 32'(want.slewing));
          if (got.error_left !== want.error_left)
            report("error_left", 32'(got.error_left), 32'(want.error_left));
        end
      end
      if (in_valid && in_ready) begin
        step_clock(in_data, fresh);
        owed_readings.push_back(fresh);
      end
    end
    results_owed <= owed_readings.size();
    counter_now  <= secs;
  end

endmodule

@@ bench/rtc_seconds_slew_corrector_unit_tb.sv @@
module rtc_seconds_slew_corrector_unit_tb;
  import rscu_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;

  int                fail_count;
  int                results_seen;
  int                results_owed;
  logic [SECS_W-1:0] counter_now;

  bit                steady;
  int                ticks_sent;
  int                sets_sent;
  logic [SECS_W-1:0] base;

  rtc_seconds_slew_corrector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rscu_slew_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .results_owed (results_owed),
    .counter_now  (counter_now)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  task automatic send(input logic op, input logic [SECS_W-1:0] target);
    if (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, target_time: target};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_SET) begin
      sets_sent++;
    end else begin
      ticks_sent++;
      base = base + 1;
    end
  endtask

  task automatic tick_run(input int n);
    repeat (n) send(OP_TICK, $urandom());
  endtask

  // Hold the sender until every result is out, then pick up the exact counter.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    base = counter_now;
  endtask

  // Request a time that lies off seconds behind the counter.
  task automatic set_rel(input int off);
    logic [SECS_W-1:0] t;
    t = base - off;
    send(OP_SET, t);
    if (off > int'(SLEW_LIMIT) || off < -int'(SLEW_LIMIT)) base = t;
  endtask

  initial begin
    int                pick;
    int                off;
    int                m;
    logic              op;
    logic [SECS_W-1:0] t;
    clk      = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    steady   = 1'b0;
    base     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tick_run(3);
    set_rel(0);
    send(OP_SET, 32'hFFFF_FFFE);
    base = 32'hFFFF_FFFE;
    tick_run(3);
    settle();
    set_rel(127);
    tick_run(3);
    settle();
    set_rel(128);
    settle();
    set_rel(-127);
    tick_run(3);
    settle();
    set_rel(-128);
    settle();
    send(OP_SET, base + 32'h8000_0000);
    base = base + 32'h8000_0000;
    settle();
    set_rel(1);
    tick_run(2);
    set_rel(-1);
    tick_run(2);
    send(OP_SET, '0);
    send(OP_SET, '1);
    base = '1;

    while (ticks_sent + sets_sent < 1300) begin
      steady = (ticks_sent + sets_sent >= 600) && (ticks_sent + sets_sent < 850);
      pick = $urandom_range(99);
      if (pick < 60) begin
        // slew of random size, sometimes run to completion, more often cut short
        if ($urandom_range(3) == 0) settle();
        off = $urandom_range(254);
        off -= 127;
        set_rel(off);
        m = (off < 0) ? -off : off;
        tick_run($urandom_range(2 * m + 3));
      end else if (pick < 75) begin
        t = $urandom();
        send(OP_SET, t);
        base = t;
        tick_run($urandom_range(8));
      end else if (pick < 85) begin
        settle();
        off = $urandom_range(126, 129);
        if ($urandom_range(1) == 1) off = -off;
        set_rel(off);
        tick_run($urandom_range(6));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          op = 1'($urandom_range(1));
          send(op, $urandom());
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("run covered %0d ticks and %0d set requests, %0d results compared",
             ticks_sent, sets_sent, results_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
